[design/i2cbm_pkg.sv]
package i2cbm_pkg;

	localparam int BYTE_BITS = 8;
	localparam int DELAY_WIDTH_DEF = 16;
	localparam int PHASE_TICKS_W = 16;
	localparam int POLL_W = 8;
	localparam int CFG_W = 16;

	localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RST = 16'd4;
	localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

	// configuration register indexes
	localparam logic CFG_PHASE_TICKS = 1'b0;
	localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

	// request codes
	localparam logic [2:0] REQ_START = 3'd0;
	localparam logic [2:0] REQ_STOP = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_READ = 3'd3;
	localparam logic [2:0] REQ_ACK = 3'd4;
	localparam logic [2:0] REQ_NACK = 3'd5;
	localparam logic [2:0] REQ_WAIT_ACK = 3'd6;

	typedef struct packed {
		logic cmd_valid;
		logic [2:0] req_type;
		logic [BYTE_BITS-1:0] tx_byte;
		logic sda_in;
	} in_t;

	typedef struct packed {
		logic scl_release;
		logic sda_release;
		logic busy_res;
		logic cmd_done;
		logic [BYTE_BITS-1:0] rx_byte;
		logic ack_seen;
	} out_t;

	// head of the tick queue as seen by the sequencer
	typedef struct packed {
		logic valid;
		in_t data;
	} qhead_t;

endpackage

[design/i2c_bus_master_sequencer.sv]
// Path: an accepted tick waits in the tick queue; its result is then held
// in the sequencer's result register.
// Throughput: one tick per cycle while the result side does not stall;
// a stall on the result side backs up into a two-entry queue.
// Reset: asynchronous, active low; lines released, sequencer idle,
// phase_ticks 4, ack_poll_limit 250.
module i2c_bus_master_sequencer #(
	parameter int DELAY_WIDTH = i2cbm_pkg::DELAY_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input i2cbm_pkg::in_t item,
	output logic result_valid,
	input logic result_stall,
	output i2cbm_pkg::out_t result,
	input logic cfg_we,
	input logic cfg_idx,
	input logic [i2cbm_pkg::CFG_W-1:0] cfg_data
);
	import i2cbm_pkg::*;

	logic [PHASE_TICKS_W-1:0] phase_ticks_q;
	logic [POLL_W-1:0] ack_poll_limit_q;
	qhead_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			ack_poll_limit_q <= ACK_POLL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PHASE_TICKS: phase_ticks_q <= cfg_data[PHASE_TICKS_W-1:0];
				CFG_ACK_POLL_LIMIT: ack_poll_limit_q <= cfg_data[POLL_W-1:0];
				default: ;
			endcase
		end
	end

	i2cbm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.head(head),
		.pop(pop)
	);

	i2cbm_back #(
		.DELAY_WIDTH(DELAY_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.phase_ticks(phase_ticks_q),
		.ack_poll_limit(ack_poll_limit_q),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

[design/i2cbm_front.sv]
module i2cbm_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input i2cbm_pkg::in_t item,
	output i2cbm_pkg::qhead_t head,
	input logic pop
);
	import i2cbm_pkg::*;

	in_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign item_stall = (cnt_q == 2'd2);
	assign push = item_valid && !item_stall;

	assign head.valid = (cnt_q != 2'd0);
	assign head.data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/i2cbm_back.sv]
module i2cbm_back #(
	parameter int DELAY_WIDTH = i2cbm_pkg::DELAY_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input i2cbm_pkg::qhead_t head,
	output logic pop,
	input logic [i2cbm_pkg::PHASE_TICKS_W-1:0] phase_ticks,
	input logic [i2cbm_pkg::POLL_W-1:0] ack_poll_limit,
	output logic result_valid,
	input logic result_stall,
	output i2cbm_pkg::out_t result
);
	import i2cbm_pkg::*;

	localparam int CW = (DELAY_WIDTH > PHASE_TICKS_W) ? DELAY_WIDTH : PHASE_TICKS_W;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_SP3,
		PH_AK1, PH_AK2, PH_AK3, PH_NK1, PH_NK2,
		PH_WR_LOW, PH_WR_HIGH, PH_WR_TAIL,
		PH_RD_SETUP, PH_RD_HIGH, PH_RD_LOW,
		PH_WA_HIGH, PH_WA_POLL, PH_WA_TAIL
	} phase_t;

	phase_t phase_q, phase_n;
	logic [3:0] bit_cnt_q, bit_cnt_n;
	logic [BYTE_BITS-1:0] shift_q, shift_n;
	logic [DELAY_WIDTH-1:0] delay_q, delay_n;
	logic [POLL_W-1:0] poll_q, poll_n;
	logic scl_q, scl_n;
	logic sda_q, sda_n;
	logic ack_q, ack_n;
	logic [BYTE_BITS-1:0] rx_q, rx_n;
	logic done;
	logic do_poll;
	logic take;
	logic [CW-1:0] pt_ext;
	logic [CW-1:0] cap;
	logic [CW-1:0] ld_ext;
	logic [DELAY_WIDTH-1:0] ld_val;
	out_t res_q;
	logic res_valid_q;
	in_t tk;

	// delay reload: zero counts as one, saturate to counter width
	always_comb begin
		pt_ext = CW'(phase_ticks);
		cap = CW'({DELAY_WIDTH{1'b1}});
		if (pt_ext == '0) begin
			ld_ext = CW'(1);
		end else if (pt_ext > cap) begin
			ld_ext = cap;
		end else begin
			ld_ext = pt_ext;
		end
		ld_val = ld_ext[DELAY_WIDTH-1:0];
	end

	assign tk = head.data;
	assign take = head.valid && (!res_valid_q || !result_stall);
	assign pop = take;

	always_comb begin
		phase_n = phase_q;
		bit_cnt_n = bit_cnt_q;
		shift_n = shift_q;
		delay_n = delay_q;
		poll_n = poll_q;
		scl_n = scl_q;
		sda_n = sda_q;
		ack_n = ack_q;
		rx_n = rx_q;
		done = 1'b0;
		do_poll = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (tk.cmd_valid) begin
				case (tk.req_type)
					REQ_START: begin
						bit_cnt_n = 4'd0; sda_n = 1'b1;
						phase_n = PH_ST1; delay_n = ld_val;
					end
					REQ_STOP: begin
						bit_cnt_n = 4'd0; sda_n = 1'b0;
						phase_n = PH_SP1; delay_n = ld_val;
					end
					REQ_WRITE: begin
						bit_cnt_n = 4'd0; scl_n = 1'b0;
						sda_n = tk.tx_byte[BYTE_BITS-1];
						shift_n = {tk.tx_byte[BYTE_BITS-2:0], 1'b0};
						phase_n = PH_WR_LOW; delay_n = ld_val;
					end
					REQ_READ: begin
						bit_cnt_n = 4'd0; scl_n = 1'b0; sda_n = 1'b1; shift_n = '0;
						phase_n = PH_RD_SETUP; delay_n = ld_val;
					end
					REQ_ACK: begin
						bit_cnt_n = 4'd0; sda_n = 1'b0;
						phase_n = PH_AK1; delay_n = ld_val;
					end
					REQ_NACK: begin
						bit_cnt_n = 4'd0; sda_n = 1'b1;
						phase_n = PH_NK1; delay_n = ld_val;
					end
					REQ_WAIT_ACK: begin
						bit_cnt_n = 4'd0; sda_n = 1'b1; scl_n = 1'b1; poll_n = '0;
						phase_n = PH_WA_HIGH; delay_n = ld_val;
					end
					default: ;
				endcase
			end
		end else if (phase_q == PH_WA_POLL) begin
			do_poll = 1'b1;
		end else if (delay_q > DELAY_WIDTH'(1)) begin
			delay_n = delay_q - DELAY_WIDTH'(1);
		end else begin
			delay_n = '0;
			case (phase_q)
				PH_ST1: begin scl_n = 1'b1; phase_n = PH_ST2; delay_n = ld_val; end
				PH_ST2: begin sda_n = 1'b0; phase_n = PH_ST3; delay_n = ld_val; end
				PH_ST3: begin scl_n = 1'b0; done = 1'b1; end
				PH_SP1: begin scl_n = 1'b1; phase_n = PH_SP2; delay_n = ld_val; end
				PH_SP2: begin sda_n = 1'b1; phase_n = PH_SP3; delay_n = ld_val; end
				PH_AK1: begin scl_n = 1'b1; phase_n = PH_AK2; delay_n = ld_val; end
				PH_AK2: begin scl_n = 1'b0; phase_n = PH_AK3; delay_n = ld_val; end
				PH_NK1: begin scl_n = 1'b1; phase_n = PH_NK2; delay_n = ld_val; end
				PH_NK2: begin scl_n = 1'b0; done = 1'b1; end
				PH_WR_LOW: begin scl_n = 1'b1; phase_n = PH_WR_HIGH; delay_n = ld_val; end
				PH_WR_HIGH: begin scl_n = 1'b0; phase_n = PH_WR_TAIL; delay_n = ld_val; end
				PH_WR_TAIL: begin
					bit_cnt_n = bit_cnt_q + 4'd1;
					if (bit_cnt_n >= 4'(BYTE_BITS)) begin
						done = 1'b1;
					end else begin
						sda_n = shift_q[BYTE_BITS-1];
						shift_n = {shift_q[BYTE_BITS-2:0], 1'b0};
						phase_n = PH_WR_LOW;
						delay_n = ld_val;
					end
				end
				PH_RD_SETUP: begin scl_n = 1'b1; phase_n = PH_RD_HIGH; delay_n = ld_val; end
				PH_RD_HIGH: begin
					// sample SDA as SCL drops
					shift_n = {shift_q[BYTE_BITS-2:0], tk.sda_in};
					scl_n = 1'b0;
					phase_n = PH_RD_LOW;
					delay_n = ld_val;
				end
				PH_RD_LOW: begin
					bit_cnt_n = bit_cnt_q + 4'd1;
					if (bit_cnt_n >= 4'(BYTE_BITS)) begin
						rx_n = shift_q;
						done = 1'b1;
					end else begin
						scl_n = 1'b1;
						phase_n = PH_RD_HIGH;
						delay_n = ld_val;
					end
				end
				PH_WA_HIGH: do_poll = 1'b1;
				default: done = 1'b1;
			endcase
		end

		if (do_poll) begin
			if (!tk.sda_in) begin
				ack_n = 1'b1;
				scl_n = 1'b0;
				phase_n = PH_WA_TAIL;
				delay_n = ld_val;
			end else if (poll_q < ack_poll_limit) begin
				poll_n = poll_q + POLL_W'(1);
				phase_n = PH_WA_POLL;
			end else begin
				ack_n = 1'b0;
				scl_n = 1'b0;
				phase_n = PH_WA_TAIL;
				delay_n = ld_val;
			end
		end

		if (done) begin
			phase_n = PH_IDLE;
			delay_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_cnt_q <= 4'd0;
			shift_q <= '0;
			delay_q <= '0;
			poll_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			ack_q <= 1'b0;
			rx_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_n;
				bit_cnt_q <= bit_cnt_n;
				shift_q <= shift_n;
				delay_q <= delay_n;
				poll_q <= poll_n;
				scl_q <= scl_n;
				sda_q <= sda_n;
				ack_q <= ack_n;
				rx_q <= rx_n;
				res_valid_q <= 1'b1;
				res_q.scl_release <= scl_n;
				res_q.sda_release <= sda_n;
				res_q.busy_res <= (phase_n != PH_IDLE);
				res_q.cmd_done <= done;
				res_q.rx_byte <= rx_n;
				res_q.ack_seen <= ack_n;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

[tb/sv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cbm_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD = 300;

	typedef enum logic [4:0] {
		P_IDLE,
		P_START_SCL, P_START_SDA, P_START_END,
		P_STOP_SCL, P_STOP_SDA, P_STOP_END,
		P_ACK_HIGH, P_ACK_LOW, P_ACK_END,
		P_NACK_HIGH, P_NACK_END,
		P_WR_LOW, P_WR_HIGH, P_WR_TAIL,
		P_RD_SETUP, P_RD_HIGH, P_RD_LOW,
		P_WA_HIGH, P_WA_POLL, P_WA_TAIL
	} seq_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;
	logic cfg_we;
	logic cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	// bus sequencer state as predicted
	seq_phase_t m_phase;
	logic [3:0] m_bits;
	logic [7:0] m_shift;
	logic [15:0] m_delay;
	logic [7:0] m_polls;
	logic m_scl, m_sda, m_ack;
	logic [7:0] m_rx;
	logic [15:0] m_ticks_cfg;
	logic [7:0] m_poll_cfg;

	out_t levels_due[$];
	int errors = 0;
	int ticks_sent = 0;
	int cycles = 0;
	int idle_odds = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	i2c_bus_master_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic void goto_phase(seq_phase_t p);
		m_phase = p;
		m_delay = (m_ticks_cfg == 16'd0) ? 16'd1 : m_ticks_cfg;
	endfunction

	function automatic void poll_sda(logic sda);
		if (!sda) begin
			m_ack = 1'b1;
		end else if (m_polls < m_poll_cfg) begin
			m_polls = m_polls + 8'd1;
			m_phase = P_WA_POLL;
			return;
		end else begin
			m_ack = 1'b0;
		end
		m_scl = 1'b0;
		goto_phase(P_WA_TAIL);
	endfunction

	// returns 1 when the running request ends on this tick
	function automatic bit phase_expired(logic sda);
		case (m_phase)
			P_START_SCL: begin m_scl = 1'b1; goto_phase(P_START_SDA); end
			P_START_SDA: begin m_sda = 1'b0; goto_phase(P_START_END); end
			P_START_END: begin m_scl = 1'b0; return 1'b1; end
			P_STOP_SCL: begin m_scl = 1'b1; goto_phase(P_STOP_SDA); end
			P_STOP_SDA: begin m_sda = 1'b1; goto_phase(P_STOP_END); end
			P_ACK_HIGH: begin m_scl = 1'b1; goto_phase(P_ACK_LOW); end
			P_ACK_LOW: begin m_scl = 1'b0; goto_phase(P_ACK_END); end
			P_NACK_HIGH: begin m_scl = 1'b1; goto_phase(P_NACK_END); end
			P_NACK_END: begin m_scl = 1'b0; return 1'b1; end
			P_WR_LOW: begin m_scl = 1'b1; goto_phase(P_WR_HIGH); end
			P_WR_HIGH: begin m_scl = 1'b0; goto_phase(P_WR_TAIL); end
			P_WR_TAIL: begin
				m_bits = m_bits + 4'd1;
				if (m_bits >= BYTE_BITS)
					return 1'b1;
				m_sda = m_shift[7];
				m_shift = {m_shift[6:0], 1'b0};
				goto_phase(P_WR_LOW);
			end
			P_RD_SETUP: begin m_scl = 1'b1; goto_phase(P_RD_HIGH); end
			P_RD_HIGH: begin
				m_shift = {m_shift[6:0], sda};
				m_scl = 1'b0;
				goto_phase(P_RD_LOW);
			end
			P_RD_LOW: begin
				m_bits = m_bits + 4'd1;
				if (m_bits >= BYTE_BITS) begin
					m_rx = m_shift;
					return 1'b1;
				end
				m_scl = 1'b1;
				goto_phase(P_RD_HIGH);
			end
			P_WA_HIGH: poll_sda(sda);
			default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	function automatic out_t bus_levels_after(in_t t);
		out_t r;
		logic done;
		done = 1'b0;
		if (m_phase == P_IDLE) begin
			if (t.cmd_valid) begin
				m_bits = 4'd0;
				case (t.req_type)
					REQ_START: begin m_sda = 1'b1; goto_phase(P_START_SCL); end
					REQ_STOP: begin m_sda = 1'b0; goto_phase(P_STOP_SCL); end
					REQ_WRITE: begin
						m_scl = 1'b0;
						m_sda = t.tx_byte[7];
						m_shift = {t.tx_byte[6:0], 1'b0};
						goto_phase(P_WR_LOW);
					end
					REQ_READ: begin
						m_scl = 1'b0;
						m_sda = 1'b1;
						m_shift = 8'd0;
						goto_phase(P_RD_SETUP);
					end
					REQ_ACK: begin m_sda = 1'b0; goto_phase(P_ACK_HIGH); end
					REQ_NACK: begin m_sda = 1'b1; goto_phase(P_NACK_HIGH); end
					REQ_WAIT_ACK: begin
						m_sda = 1'b1;
						m_scl = 1'b1;
						m_polls = 8'd0;
						goto_phase(P_WA_HIGH);
					end
					default: ;
				endcase
			end
		end else if (m_phase == P_WA_POLL) begin
			poll_sda(t.sda_in);
		end else if (m_delay > 16'd1) begin
			m_delay = m_delay - 16'd1;
		end else begin
			m_delay = 16'd0;
			done = phase_expired(t.sda_in);
			if (done) begin
				m_phase = P_IDLE;
				m_delay = 16'd0;
			end
		end
		r.scl_release = m_scl;
		r.sda_release = m_sda;
		r.busy_res = (m_phase != P_IDLE);
		r.cmd_done = done;
		r.rx_byte = m_rx;
		r.ack_seen = m_ack;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (levels_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $time, result);
			end else begin
				want = levels_due.pop_front();
				check_field("scl_release", want.scl_release, result.scl_release);
				check_field("sda_release", want.sda_release, result.sda_release);
				check_field("busy_res", want.busy_res, result.busy_res);
				check_field("cmd_done", want.cmd_done, result.cmd_done);
				check_field("rx_byte", want.rx_byte, result.rx_byte);
				check_field("ack_seen", want.ack_seen, result.ack_seen);
			end
		end
	end

	// result side: random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			stall_left = $urandom_range(1, 10) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic send_tick(in_t t);
		int gap;
		if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			gap = $urandom_range(1, 10);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= t;
		do
			@(posedge clk);
		while (item_stall);
		ticks_sent++;
		levels_due.push_back(bus_levels_after(t));
	endtask

	// offer one request once idle, then tick until it has finished
	task automatic run_request(logic [2:0] req, logic [7:0] tx, int low_pct, bit noisy);
		in_t t;
		bit sent;
		sent = 1'b0;
		while (!sent || m_phase != P_IDLE) begin
			t.sda_in = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
			t.tx_byte = 8'($urandom_range(0, 255));
			t.req_type = 3'($urandom_range(0, 7));
			t.cmd_valid = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
			if (!sent && m_phase == P_IDLE) begin
				t.cmd_valid = 1'b1;
				t.req_type = req;
				t.tx_byte = tx;
				sent = 1'b1;
			end
			send_tick(t);
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PHASE_TICKS)
			m_ticks_cfg = v;
		else
			m_poll_cfg = v[7:0];
	endtask

	// start, address, ack, a few data bytes, stop
	task automatic run_transfer();
		int n;
		bit noisy;
		noisy = 1'($urandom_range(0, 1));
		n = $urandom_range(1, 3);
		run_request(REQ_START, 8'($urandom_range(0, 255)), 50, noisy);
		run_request(REQ_WRITE, 8'($urandom_range(0, 255)), 50, noisy);
		run_request(REQ_WAIT_ACK, 0, ($urandom_range(0, 3) == 0) ? 0 : 40, noisy);
		repeat (n) begin
			if ($urandom_range(0, 1)) begin
				run_request(REQ_WRITE, 8'($urandom_range(0, 255)), 50, noisy);
				run_request(REQ_WAIT_ACK, 0, ($urandom_range(0, 3) == 0) ? 0 : 40, noisy);
			end else begin
				run_request(REQ_READ, 0, 50, noisy);
				run_request($urandom_range(0, 1) ? REQ_ACK : REQ_NACK, 0, 50, noisy);
			end
		end
		run_request(REQ_STOP, 0, 50, noisy);
	endtask

	task automatic test_reset_state();
		in_t t;
		repeat (3) begin
			t = '0;
			t.sda_in = 1'($urandom_range(0, 1));
			t.tx_byte = 8'($urandom_range(0, 255));
			send_tick(t);
		end
	endtask

	task automatic test_requests();
		idle_odds = 4;
		run_request(REQ_START, 8'h00, 50, 1'b0);
		// no ack: poll out the full reset limit
		run_request(REQ_WAIT_ACK, 8'h00, 0, 1'b0);
		write_reg(CFG_PHASE_TICKS, 16'd1);
		run_request(REQ_WRITE, 8'hFF, 50, 1'b0);
		run_request(REQ_WRITE, 8'h00, 50, 1'b0);
		run_request(REQ_WAIT_ACK, 8'h00, 100, 1'b0);
		run_request(REQ_READ, 8'h00, 0, 1'b0);
		run_request(REQ_READ, 8'h00, 100, 1'b0);
		run_request(REQ_READ, 8'h00, 50, 1'b0);
		run_request(REQ_ACK, 8'h00, 50, 1'b0);
		run_request(REQ_NACK, 8'h00, 50, 1'b0);
		run_request(REQ_STOP, 8'h00, 50, 1'b0);
		run_request(3'd7, 8'hFF, 50, 1'b0);
		// requests offered while busy are dropped
		run_request(REQ_WRITE, 8'hA5, 50, 1'b1);
		run_request(REQ_WAIT_ACK, 8'h00, 30, 1'b1);
	endtask

	task automatic test_timing_extremes();
		idle_odds = 4;
		write_reg(CFG_PHASE_TICKS, 16'd0);
		run_request(REQ_START, 8'h00, 50, 1'b0);
		run_request(REQ_STOP, 8'h00, 50, 1'b0);
		write_reg(CFG_PHASE_TICKS, 16'd1);
		run_request(REQ_WRITE, 8'h5A, 50, 1'b0);
		run_request(REQ_READ, 8'h00, 50, 1'b0);
		run_request(REQ_WAIT_ACK, 8'h00, 100, 1'b0);
		write_reg(CFG_ACK_POLL_LIMIT, 16'h0000);
		run_request(REQ_WAIT_ACK, 8'h00, 0, 1'b0);
		// upper data bits are dropped
		write_reg(CFG_ACK_POLL_LIMIT, 16'hFF08);
		run_request(REQ_WAIT_ACK, 8'h00, 0, 1'b0);
		// long phase: keep both sides busy so it stays short in cycles
		idle_odds = 0;
		write_reg(CFG_PHASE_TICKS, 16'd40);
		run_request(REQ_NACK, 8'h00, 50, 1'b0);
		idle_odds = 4;
		write_reg(CFG_PHASE_TICKS, 16'd2);
		write_reg(CFG_ACK_POLL_LIMIT, 16'h0006);
	endtask

	task automatic test_backpressure();
		idle_odds = 0;
		hold_asks <= hold_asks + 1;
		run_transfer();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int next_cfg;
		logic [CFG_W-1:0] v;
		idle_odds = 6;
		stop_at = ticks_sent + 250;
		next_cfg = ticks_sent;
		while (ticks_sent < stop_at) begin
			if (ticks_sent >= next_cfg) begin
				case ($urandom_range(0, 9))
					0: v = 16'd0;
					1: v = 16'($urandom_range(5, 6));
					default: v = 16'($urandom_range(1, 3));
				endcase
				write_reg(CFG_PHASE_TICKS, v);
				v = 16'($urandom_range(0, 65535));
				case ($urandom_range(0, 9))
					0: v[7:0] = 8'd0;
					1: v[7:0] = 8'd255;
					default: v[7:0] = 8'($urandom_range(1, 8));
				endcase
				write_reg(CFG_ACK_POLL_LIMIT, v);
				next_cfg = ticks_sent + 100;
			end
			if ($urandom_range(0, 4) != 0)
				run_transfer();
			else
				run_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 50,
					1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_quiet_finish();
		idle_odds = 0;
		write_reg(CFG_PHASE_TICKS, 16'd1);
		run_transfer();
		run_transfer();
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_PHASE_TICKS;
		cfg_data <= '0;
		m_phase = P_IDLE;
		m_bits = 4'd0;
		m_shift = 8'd0;
		m_delay = 16'd0;
		m_polls = 8'd0;
		m_scl = 1'b1;
		m_sda = 1'b1;
		m_ack = 1'b0;
		m_rx = 8'd0;
		m_ticks_cfg = PHASE_TICKS_RST;
		m_poll_cfg = ACK_POLL_LIMIT_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_requests();
		test_timing_extremes();
		test_backpressure();
		test_random_traffic();
		test_quiet_finish();

		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0 && levels_due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[i2c_bus_master_sequencer.f]
design/i2cbm_pkg.sv
design/i2cbm_front.sv
design/i2cbm_back.sv
design/i2c_bus_master_sequencer.sv
tb/sv/testbench.sv
